>>> src/ukst_pkg.sv
package ukst_pkg;

    // table geometry
    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int COUNT_W   = 5;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [CNT_W-1:0]     t_cnt;

    // operation codes; the unused code behaves as a lookup
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // per-cell control from the sequencer
    typedef struct packed {
        logic valid;   // cell holds a live entry
        logic remove;  // remove operation in progress
        logic append;  // cell takes the search key
    } t_cell_ctl;

endpackage

>>> src/ukst_cell.sv
module ukst_cell (
    input  logic              i_clk,
    input  ukst_pkg::t_cell_ctl i_ctl,
    input  ukst_pkg::t_key    i_search_key,
    input  ukst_pkg::t_key    i_next_key,
    input  logic              i_shift_in,
    output logic              o_shift_out,
    output ukst_pkg::t_key    o_key
);
    import ukst_pkg::*;

    t_key r_key;
    logic w_match;

    // compare against the live entry only
    assign w_match     = i_ctl.valid && (r_key == i_search_key);

    // from the matching cell on, every cell pulls its neighbor down on a remove
    assign o_shift_out = i_shift_in || w_match;
    assign o_key       = r_key;

    // entry storage: append or shift down from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            r_key <= i_search_key;
        end else if (i_ctl.remove && o_shift_out) begin
            r_key <= i_next_key;
        end
    end

endmodule

>>> src/unique_key_set_table.sv
// A start is taken into the command register, and its result into the result registers.
// Throughput: one item per cycle; busy stays low, the command register and
// the cell row work back to back and each item sees the previous update.
// Reset clears the entry count and the pipeline strobes; the key cells are
// not cleared. Results appear for one cycle on o_valid; the receiver cannot stall.
module unique_key_set_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic [ukst_pkg::KEY_WIDTH-1:0] i_key,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic                          o_hit,
    output logic [ukst_pkg::COUNT_W-1:0]  o_count
);
    import ukst_pkg::*;

    logic                r_cmd_valid;
    logic [1:0]          r_op;
    t_key                r_key;
    t_cnt                r_count;
    t_cnt                n_count;
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [1:0]          n_status;
    logic                r_hit;

    logic [CAPACITY:0]   w_shift;
    t_key                w_cell_key [CAPACITY];
    logic                w_hit;
    logic                w_is_add;
    logic                w_is_remove;
    logic                w_full;
    logic                w_add_ok;

    assign busy = 1'b0;

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else begin
            r_cmd_valid <= start;
        end
        if (start) begin
            r_op  <= i_operation;
            r_key <= i_key;
        end
    end

    // decode
    assign w_is_add    = r_cmd_valid && (r_op == OP_ADD);
    assign w_is_remove = r_cmd_valid && (r_op == OP_REMOVE);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_hit       = w_shift[CAPACITY];
    assign w_add_ok    = w_is_add && !w_hit && !w_full;

    // row of cells; the shift chain also carries the hit
    assign w_shift[0] = 1'b0;
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_ctl w_ctl;
        t_key      w_next;

        assign w_ctl.valid  = (r_count > CNT_W'(i));
        assign w_ctl.remove = w_is_remove;
        assign w_ctl.append = w_add_ok && (r_count == CNT_W'(i));

        if (i == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_key[i+1];
        end

        ukst_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_search_key (r_key),
            .i_next_key   (w_next),
            .i_shift_in   (w_shift[i]),
            .o_shift_out  (w_shift[i+1]),
            .o_key        (w_cell_key[i])
        );
    end

    // status and next count
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        if (w_is_add) begin
            if (w_hit) begin
                n_status = ST_DUP;
            end else if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (w_is_remove) begin
            if (!w_hit) begin
                n_status = ST_MISSING;
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    // count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_cmd_valid;
            if (r_cmd_valid) begin
                r_count <= n_count;
            end
        end
        if (r_cmd_valid) begin
            r_status <= n_status;
            r_hit    <= w_hit;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_hit    = r_hit;
    assign o_count  = COUNT_W'(r_count);

endmodule
